>>> src/pwcf_pkg.sv
package pwcf_pkg;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_RISE = 2'd1,
      REQ_FALL = 2'd2,
      REQ_READ = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_MIN_WIDTH = 2'd0,
      CSR_MAX_WIDTH = 2'd1,
      CSR_TICK_SCALE = 2'd2,
      CSR_CAPTURE_EN = 2'd3
   } csr_index_type;

   localparam int WIDTH_W = 24;
   localparam int STAMP_W = 32;
   localparam int SCALE_W = 16;
   localparam int FRAC_BITS = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [WIDTH_W-1:0] WIDTH_MAX = 24'hFFFFFF;
   localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 24'd6000;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 24'd14000;
   localparam logic [SCALE_W-1:0] TICK_SCALE_RESET = 16'd256;
   localparam logic CAPTURE_EN_RESET = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_ADDR_W = 2;
   localparam int CREDIT_W = 3;

   typedef struct packed {
      req_kind_type req_type;
      logic [STAMP_W-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic entry_valid;
      logic [WIDTH_W-1:0] width_us;
      logic [STAMP_W-1:0] stamp_ms;
   } rsp_payload_type;

endpackage

>>> src/pwcf_stream_if.sv
interface pwcf_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/pwcf_ram.sv
module pwcf_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input logic clock,
   input logic write_en,
   input logic [ADDR_W-1:0] write_addr,
   input logic [WIDTH-1:0] write_data,
   input logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

>>> src/pulse_width_capture_fifo_top.sv
// Read item: its result is registered in stage 1, stage 2 and the output queue before rsp_chan shows it.
// Tick and rising edge items take effect at once; a falling edge item reaches the store in the next cycle.
// Throughput: one item per cycle; req_chan.ready drops only while four read
// results are outstanding, the depth of the output queue.
// Reset (synchronous): clears count, timestamp, FIFO pointers, fill count and
// output queue; registers return to defaults. Store contents are not cleared.
module pulse_width_capture_fifo_top #(
   parameter int FIFO_DEPTH = 16,
   parameter int COUNT_WIDTH = 24
) (
   input logic clock,
   input logic reset,
   pwcf_stream_if.sink req_chan,
   pwcf_stream_if.source rsp_chan,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [pwcf_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [pwcf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pwcf_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   localparam int ADDR_W = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam int PROD_W = COUNT_WIDTH + pwcf_pkg::SCALE_W;
   localparam int SHIFT_W = PROD_W - pwcf_pkg::FRAC_BITS;
   localparam int ENTRY_W = pwcf_pkg::WIDTH_W + pwcf_pkg::STAMP_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
      next_slot = (p == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : p + ADDR_W'(1);
   endfunction

   // configuration registers
   logic [pwcf_pkg::WIDTH_W-1:0] min_width_ff;
   logic [pwcf_pkg::WIDTH_W-1:0] max_width_ff;
   logic [pwcf_pkg::SCALE_W-1:0] scale_ff;
   logic enable_ff;
   logic csr_write;
   pwcf_pkg::csr_index_type csr_index;

   assign pready = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = pwcf_pkg::csr_index_type'(paddr[pwcf_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= pwcf_pkg::MIN_WIDTH_RESET;
         max_width_ff <= pwcf_pkg::MAX_WIDTH_RESET;
         scale_ff <= pwcf_pkg::TICK_SCALE_RESET;
         enable_ff <= pwcf_pkg::CAPTURE_EN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            pwcf_pkg::CSR_MIN_WIDTH: min_width_ff <= pwdata[pwcf_pkg::WIDTH_W-1:0];
            pwcf_pkg::CSR_MAX_WIDTH: max_width_ff <= pwdata[pwcf_pkg::WIDTH_W-1:0];
            pwcf_pkg::CSR_TICK_SCALE: scale_ff <= pwdata[pwcf_pkg::SCALE_W-1:0];
            pwcf_pkg::CSR_CAPTURE_EN: enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pwcf_pkg::CSR_MIN_WIDTH: prdata = pwcf_pkg::CSR_DATA_W'(min_width_ff);
         pwcf_pkg::CSR_MAX_WIDTH: prdata = pwcf_pkg::CSR_DATA_W'(max_width_ff);
         pwcf_pkg::CSR_TICK_SCALE: prdata = pwcf_pkg::CSR_DATA_W'(scale_ff);
         pwcf_pkg::CSR_CAPTURE_EN: prdata = pwcf_pkg::CSR_DATA_W'(enable_ff);
         default: prdata = '0;
      endcase
   end

   // accept
   logic [pwcf_pkg::CREDIT_W-1:0] credit_ff, credit_in;
   logic req_fire;
   logic read_fire;
   pwcf_pkg::req_kind_type req_kind;

   assign req_chan.ready = credit_ff < pwcf_pkg::CREDIT_W'(pwcf_pkg::QUEUE_DEPTH);
   assign req_fire = req_chan.valid & req_chan.ready;
   assign req_kind = req_chan.payload.req_type;
   assign read_fire = req_fire && (req_kind == pwcf_pkg::REQ_READ);

   // pulse count and start time
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [pwcf_pkg::STAMP_W-1:0] start_ff, start_in;

   always_comb begin
      elapsed_in = elapsed_ff;
      start_in = start_ff;
      if (req_fire) begin
         case (req_kind)
            pwcf_pkg::REQ_TICK: begin
               if (elapsed_ff != COUNT_MAX) begin
                  elapsed_in = elapsed_ff + COUNT_WIDTH'(1);
               end
            end
            pwcf_pkg::REQ_RISE: begin
               if (enable_ff) begin
                  elapsed_in = '0;
                  start_in = req_chan.payload.now_ms;
               end
            end
            default: ;
         endcase
      end
   end

   // stage 1: scaled product
   logic s1_push_ff, s1_read_ff;
   logic [PROD_W-1:0] s1_product_ff;
   logic [pwcf_pkg::STAMP_W-1:0] s1_stamp_ff;
   logic [SHIFT_W-1:0] shifted;
   logic [pwcf_pkg::WIDTH_W-1:0] width_sat;
   logic push_ok, read_hit;

   assign shifted = s1_product_ff[PROD_W-1:pwcf_pkg::FRAC_BITS];
   assign width_sat = (shifted > SHIFT_W'(pwcf_pkg::WIDTH_MAX)) ? pwcf_pkg::WIDTH_MAX
                                                                : shifted[pwcf_pkg::WIDTH_W-1:0];
   assign push_ok = s1_push_ff && (width_sat >= min_width_ff) && (width_sat <= max_width_ff);

   // FIFO pointers
   logic [ADDR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic fifo_full;

   assign fifo_full = fill_ff == FILL_W'(FIFO_DEPTH);
   assign read_hit = s1_read_ff && (fill_ff != '0);

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push_ok) begin
         wptr_in = next_slot(wptr_ff);
         if (fifo_full) begin
            rptr_in = next_slot(rptr_ff);
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (read_hit) begin
         rptr_in = next_slot(rptr_ff);
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   logic [ENTRY_W-1:0] ram_rdata;

   pwcf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(FIFO_DEPTH)
   ) u_store (
      .clock(clock),
      .write_en(push_ok),
      .write_addr(wptr_ff),
      .write_data({width_sat, s1_stamp_ff}),
      .read_addr(rptr_ff),
      .read_data(ram_rdata)
   );

   // stage 2: form result
   logic s2_valid_ff, s2_hit_ff;
   pwcf_pkg::rsp_payload_type s2_result;

   always_comb begin
      s2_result.entry_valid = s2_hit_ff;
      s2_result.width_us = s2_hit_ff ? ram_rdata[ENTRY_W-1:pwcf_pkg::STAMP_W] : '0;
      s2_result.stamp_ms = s2_hit_ff ? ram_rdata[pwcf_pkg::STAMP_W-1:0] : '0;
   end

   // output queue
   pwcf_pkg::rsp_payload_type q_data_ff [pwcf_pkg::QUEUE_DEPTH];
   logic [pwcf_pkg::QUEUE_ADDR_W-1:0] q_head_ff, q_head_in, q_tail_ff, q_tail_in;
   logic [pwcf_pkg::CREDIT_W-1:0] q_count_ff, q_count_in;
   logic rsp_fire;

   assign rsp_chan.valid = q_count_ff != '0;
   assign rsp_chan.payload = q_data_ff[q_head_ff];
   assign rsp_fire = rsp_chan.valid & rsp_chan.ready;

   always_comb begin
      q_head_in = rsp_fire ? q_head_ff + pwcf_pkg::QUEUE_ADDR_W'(1) : q_head_ff;
      q_tail_in = s2_valid_ff ? q_tail_ff + pwcf_pkg::QUEUE_ADDR_W'(1) : q_tail_ff;
      q_count_in = q_count_ff + pwcf_pkg::CREDIT_W'(s2_valid_ff)
                   - pwcf_pkg::CREDIT_W'(rsp_fire);
      credit_in = credit_ff + pwcf_pkg::CREDIT_W'(read_fire)
                  - pwcf_pkg::CREDIT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         q_data_ff[q_tail_ff] <= s2_result;
      end
      s1_product_ff <= PROD_W'(elapsed_ff) * PROD_W'(scale_ff);
      s1_stamp_ff <= start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         start_ff <= '0;
         s1_push_ff <= 1'b0;
         s1_read_ff <= 1'b0;
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
         s2_valid_ff <= 1'b0;
         s2_hit_ff <= 1'b0;
         q_head_ff <= '0;
         q_tail_ff <= '0;
         q_count_ff <= '0;
         credit_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         start_ff <= start_in;
         s1_push_ff <= req_fire && (req_kind == pwcf_pkg::REQ_FALL) && enable_ff;
         s1_read_ff <= read_fire;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
         s2_valid_ff <= s1_read_ff;
         s2_hit_ff <= read_hit;
         q_head_ff <= q_head_in;
         q_tail_ff <= q_tail_in;
         q_count_ff <= q_count_in;
         credit_ff <= credit_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FIFO_DEPTH))
      else $error("fill count above depth");

   a_queue_credit: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= credit_ff)
      else $error("output queue holds more than outstanding reads");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == pwcf_pkg::REQ_TICK) && (elapsed_ff != COUNT_MAX)
      |=> elapsed_ff == $past(elapsed_ff) + COUNT_WIDTH'(1))
      else $error("tick did not advance count");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      push_ok && fifo_full |=> fifo_full)
      else $error("push into full FIFO changed fill count");

endmodule

>>> tb/tb_pulse_width_capture_fifo_top.sv
module tb_pulse_width_capture_fifo_top;

   localparam int FIFO_DEPTH = 16;
   localparam int COUNT_WIDTH = 24;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam int N_SCRIPT = 19;
   localparam int N_PHASES = 8;

   typedef struct packed {
      pwcf_pkg::req_kind_type kind;
      logic [pwcf_pkg::STAMP_W-1:0] now;
      logic fixed;
      pwcf_pkg::rsp_payload_type want;
   } script_row_type;

   typedef struct packed {
      logic [pwcf_pkg::WIDTH_W-1:0] min_w;
      logic [pwcf_pkg::WIDTH_W-1:0] max_w;
      logic [pwcf_pkg::SCALE_W-1:0] scale;
      logic enable;
      logic [15:0] budget;
   } capture_setting_type;

   localparam script_row_type SCRIPT [N_SCRIPT] = '{
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b1, '{1'b0, 24'd0, 32'h0000_0000}},
      '{pwcf_pkg::REQ_FALL, 32'h0000_0000, 1'b0, '0},
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b1, '{1'b1, 24'd0, 32'h0000_0000}},
      '{pwcf_pkg::REQ_RISE, 32'hFFFF_FFFF, 1'b0, '0},
      '{pwcf_pkg::REQ_TICK, 32'h0000_0000, 1'b0, '0},
      '{pwcf_pkg::REQ_FALL, 32'h0000_0000, 1'b0, '0},
      '{pwcf_pkg::REQ_FALL, 32'hFFFF_FFFF, 1'b0, '0},
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b1, '{1'b1, 24'd255, 32'hFFFF_FFFF}},
      '{pwcf_pkg::REQ_READ, 32'hFFFF_FFFF, 1'b1, '{1'b1, 24'd255, 32'hFFFF_FFFF}},
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b1, '{1'b0, 24'd0, 32'h0000_0000}},
      '{pwcf_pkg::REQ_RISE, 32'h5AA5_C33C, 1'b0, '0},
      '{pwcf_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b0, '0},
      '{pwcf_pkg::REQ_TICK, 32'h0000_0000, 1'b0, '0},
      '{pwcf_pkg::REQ_FALL, 32'h0000_0000, 1'b0, '0},
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b1, '{1'b1, 24'd511, 32'h5AA5_C33C}},
      '{pwcf_pkg::REQ_TICK, 32'h1234_5678, 1'b0, '0},
      '{pwcf_pkg::REQ_FALL, 32'h8765_4321, 1'b0, '0},
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b0, '0},
      '{pwcf_pkg::REQ_READ, 32'h0000_0000, 1'b1, '{1'b0, 24'd0, 32'h0000_0000}}
   };

   localparam capture_setting_type PHASES [N_PHASES] = '{
      '{24'd0, pwcf_pkg::WIDTH_MAX, 16'h0180, 1'b1, 16'd700},
      '{24'd100, 24'd3000, 16'hFFFF, 1'b1, 16'd250},
      '{24'd0, pwcf_pkg::WIDTH_MAX, 16'h0100, 1'b0, 16'd120},
      '{pwcf_pkg::WIDTH_MAX, pwcf_pkg::WIDTH_MAX, 16'hFFFF, 1'b1, 16'd10},
      '{24'd5000, 24'd4000, 16'h0001, 1'b1, 16'd120},
      '{pwcf_pkg::MIN_WIDTH_RESET, pwcf_pkg::MAX_WIDTH_RESET, pwcf_pkg::TICK_SCALE_RESET,
        pwcf_pkg::CAPTURE_EN_RESET, 16'd20},
      '{24'd0, 24'd0, 16'h0000, 1'b1, 16'd150},
      '{24'd0, 24'd40, 16'h0040, 1'b1, 16'd300}
   };

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [pwcf_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pwcf_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pwcf_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   pwcf_stream_if #(.payload_type(pwcf_pkg::req_payload_type)) req_if ();
   pwcf_stream_if #(.payload_type(pwcf_pkg::rsp_payload_type)) rsp_if ();

   pulse_width_capture_fifo_top #(
      .FIFO_DEPTH(FIFO_DEPTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   logic [pwcf_pkg::WIDTH_W-1:0] cfg_min = pwcf_pkg::MIN_WIDTH_RESET;
   logic [pwcf_pkg::WIDTH_W-1:0] cfg_max = pwcf_pkg::MAX_WIDTH_RESET;
   logic [pwcf_pkg::SCALE_W-1:0] cfg_scale = pwcf_pkg::TICK_SCALE_RESET;
   logic cfg_enable = pwcf_pkg::CAPTURE_EN_RESET;

   logic [COUNT_WIDTH-1:0] tick_count = '0;
   logic [pwcf_pkg::STAMP_W-1:0] rise_stamp = '0;
   logic [pwcf_pkg::WIDTH_W-1:0] stored_width [FIFO_DEPTH];
   logic [pwcf_pkg::STAMP_W-1:0] stored_stamp [FIFO_DEPTH];
   int rd_slot = 0;
   int wr_slot = 0;
   int fill = 0;

   pwcf_pkg::rsp_payload_type expected_reads [$];
   int unsigned n_items = 0;
   int unsigned n_checked = 0;
   int unsigned n_empty_reads = 0;
   int unsigned n_stored = 0;
   int unsigned n_overwritten = 0;
   int unsigned n_errors = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   task automatic flag_error(input string msg);
      n_errors++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   function automatic bit predict_capture(input pwcf_pkg::req_payload_type it,
                                          output pwcf_pkg::rsp_payload_type res);
      logic [39:0] prod;
      logic [pwcf_pkg::WIDTH_W-1:0] w;
      res = '0;
      case (it.req_type)
         pwcf_pkg::REQ_TICK: begin
            if (tick_count != COUNT_MAX) tick_count++;
         end
         pwcf_pkg::REQ_RISE: begin
            if (cfg_enable) begin
               tick_count = '0;
               rise_stamp = it.now_ms;
            end
         end
         pwcf_pkg::REQ_FALL: begin
            if (cfg_enable) begin
               prod = 40'(tick_count) * 40'(cfg_scale);
               w = (prod[39:8] > 32'(pwcf_pkg::WIDTH_MAX)) ? pwcf_pkg::WIDTH_MAX : prod[31:8];
               if (w >= cfg_min && w <= cfg_max) begin
                  if (fill == FIFO_DEPTH) begin
                     rd_slot = (rd_slot + 1) % FIFO_DEPTH;
                     fill--;
                     n_overwritten++;
                  end
                  stored_width[wr_slot] = w;
                  stored_stamp[wr_slot] = rise_stamp;
                  wr_slot = (wr_slot + 1) % FIFO_DEPTH;
                  fill++;
                  n_stored++;
               end
            end
         end
         pwcf_pkg::REQ_READ: begin
            if (fill == 0) begin
               n_empty_reads++;
            end else begin
               res = '{1'b1, stored_width[rd_slot], stored_stamp[rd_slot]};
               rd_slot = (rd_slot + 1) % FIFO_DEPTH;
               fill--;
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic issue_req(input pwcf_pkg::req_kind_type kind,
                            input logic [pwcf_pkg::STAMP_W-1:0] now,
                            input bit fixed = 1'b0,
                            input pwcf_pkg::rsp_payload_type want = '0);
      pwcf_pkg::req_payload_type it;
      pwcf_pkg::rsp_payload_type res;
      it = '{req_type: kind, now_ms: now};
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      n_items++;
      if (predict_capture(it, res)) expected_reads.push_back(fixed ? want : res);
      @(negedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_reads.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(input pwcf_pkg::csr_index_type idx,
                            input logic [pwcf_pkg::CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= pwcf_pkg::CSR_ADDR_W'(4 * int'(idx));
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      case (idx)
         pwcf_pkg::CSR_MIN_WIDTH: cfg_min = data[pwcf_pkg::WIDTH_W-1:0];
         pwcf_pkg::CSR_MAX_WIDTH: cfg_max = data[pwcf_pkg::WIDTH_W-1:0];
         pwcf_pkg::CSR_TICK_SCALE: cfg_scale = data[pwcf_pkg::SCALE_W-1:0];
         pwcf_pkg::CSR_CAPTURE_EN: cfg_enable = data[0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(input capture_setting_type s);
      settle();
      csr_write(pwcf_pkg::CSR_MIN_WIDTH, pwcf_pkg::CSR_DATA_W'(s.min_w));
      csr_write(pwcf_pkg::CSR_MAX_WIDTH, pwcf_pkg::CSR_DATA_W'(s.max_w));
      csr_write(pwcf_pkg::CSR_TICK_SCALE, pwcf_pkg::CSR_DATA_W'(s.scale));
      csr_write(pwcf_pkg::CSR_CAPTURE_EN, pwcf_pkg::CSR_DATA_W'(s.enable));
   endtask

   task automatic run_pulse(input bit draining);
      longint n_lo;
      longint n_hi;
      longint n;
      longint i;
      int unsigned pick;
      n = $urandom_range(0, 24);
      if (cfg_scale != 0 && cfg_min <= cfg_max) begin
         n_lo = (longint'(cfg_min) * 256 + longint'(cfg_scale) - 1) / longint'(cfg_scale);
         n_hi = ((longint'(cfg_max) + 1) * 256 - 1) / longint'(cfg_scale);
         if (n_hi < n_lo) n_hi = n_lo;
         if (n_hi > n_lo + 24) n_hi = n_lo + 24;
         pick = $urandom_range(0, 7);
         if (n_lo <= 200) begin
            if (pick == 0 && n_lo > 0) n = n_lo - 1;
            else if (pick == 1) n = n_hi + 1;
            else if (pick > 3) n = n_lo + $urandom_range(0, int'(n_hi - n_lo));
         end
      end
      if ($urandom_range(0, 7) != 0) issue_req(pwcf_pkg::REQ_RISE, $urandom());
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 31) == 0) issue_req(pwcf_pkg::REQ_READ, $urandom());
         issue_req(pwcf_pkg::REQ_TICK, $urandom());
      end
      issue_req(pwcf_pkg::REQ_FALL, $urandom());
      if ($urandom_range(0, 4) == 0) issue_req(pwcf_pkg::REQ_FALL, $urandom());
      if (draining) repeat ($urandom_range(2, 3)) issue_req(pwcf_pkg::REQ_READ, $urandom());
      else if ($urandom_range(0, 7) == 0) issue_req(pwcf_pkg::REQ_READ, $urandom());
   endtask

   always @(negedge clock) begin
      if (quiet || reset) begin
         stall_left = 0;
         rsp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pwcf_pkg::rsp_payload_type want;
      pwcf_pkg::rsp_payload_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = rsp_if.payload;
         if (expected_reads.size() == 0) begin
            flag_error($sformatf("unexpected item %h", got));
         end else begin
            want = expected_reads.pop_front();
            n_checked++;
            if (got.entry_valid !== want.entry_valid)
               flag_error($sformatf("entry_valid %b, want %b", got.entry_valid,
                                    want.entry_valid));
            if (got.width_us !== want.width_us)
               flag_error($sformatf("width_us %0d, want %0d", got.width_us,
                                    want.width_us));
            if (got.stamp_ms !== want.stamp_ms)
               flag_error($sformatf("stamp_ms %h, want %h", got.stamp_ms,
                                    want.stamp_ms));
         end
      end
   end

   initial begin
      int p;
      int seq_no;
      int unsigned phase_start;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      seq_no = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      apply_setting('{24'd0, pwcf_pkg::WIDTH_MAX, 16'hFFFF, 1'b1, 16'd0});
      for (p = 0; p < N_SCRIPT; p++)
         issue_req(SCRIPT[p].kind, SCRIPT[p].now, SCRIPT[p].fixed, SCRIPT[p].want);
      for (p = 0; p < N_PHASES; p++) begin
         apply_setting(PHASES[p]);
         quiet = (p == N_PHASES - 1);
         phase_start = n_items;
         while (n_items - phase_start < PHASES[p].budget) begin
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 3))
                  issue_req(pwcf_pkg::req_kind_type'($urandom_range(0, 3)), $urandom());
            else
               run_pulse((seq_no % 36) >= 24);
            seq_no++;
         end
      end
      repeat (20) issue_req(pwcf_pkg::REQ_READ, $urandom());
      settle();
      $display("Sent %0d items over %0d settings; checked %0d read results, %0d of them empty.",
               n_items, N_PHASES + 1, n_checked, n_empty_reads);
      $display("Pulses stored: %0d, oldest entries overwritten: %0d.", n_stored,
               n_overwritten);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timeout: %0d read results still outstanding", expected_reads.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
src/pwcf_pkg.sv
src/pwcf_stream_if.sv
src/pwcf_ram.sv
src/pulse_width_capture_fifo_top.sv
tb/tb_pulse_width_capture_fifo_top.sv
